>>> src/ac_rms_window_meter_unit_defines.svh
// Assertion macros for the checker file of the RMS window meter.
`ifndef AC_RMS_WINDOW_METER_UNIT_DEFINES_SVH
`define AC_RMS_WINDOW_METER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACRMS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACRMS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/acrms_pkg.sv
package acrms_pkg;

  // Configuration port geometry
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int WINDOW_BITS = 8;
  localparam int COUNT_BITS  = 8;

  // Register indexes, decoded from paddr[2]
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_MIDPOINT = 1'b0;
  localparam reg_idx_t REG_WINDOW   = 1'b1;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd20;

endpackage

>>> src/ac_rms_window_meter_unit.sv
// A sample that closes no window is squared, then accumulated, and the block returns
// to idle; it takes no new sample until then. A window-closing sample is followed by
// the divide, root and done states before the next item can be accepted, and its
// result is registered in the done state; the shared subtractor yields one quotient
// bit, then one root bit, per cycle.
// Reset (rst, synchronous): state idle, gate disarmed, result_valid, sum, count and previous sample cleared.
module ac_rms_window_meter_unit
  import acrms_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [DATA_BITS-1:0]     pwdata,
  output logic [DATA_BITS-1:0]     prdata,
  output logic                     pready,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [SAMPLE_BITS-1:0]   rms_value,
  output logic [2*SAMPLE_BITS-1:0] mean_square,
  output logic [COUNT_BITS-1:0]    window_count
);

  localparam int SUM_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int MS_BITS   = 2 * SAMPLE_BITS;
  localparam int UW        = SAMPLE_BITS + 2;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0] prev;
  logic                   armed;
  logic [MS_BITS-1:0]     sq;
  logic [SUM_BITS-1:0]    sum;
  logic [COUNT_BITS-1:0]  count;
  logic [UW-1:0]          rem;
  logic [SAMPLE_BITS-1:0] root;
  logic [MS_BITS-1:0]     ms;
  logic [STEP_BITS-1:0]   step;

  logic [SAMPLE_BITS-1:0] midpoint_level;
  logic [WINDOW_BITS-1:0] window_length;
  logic [WINDOW_BITS-1:0] win;
  logic [COUNT_BITS-1:0]  count_next;
  logic [SUM_BITS-1:0]    sum_next;
  logic                   window_done;

  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic [UW-1:0] alu_diff;
  logic          alu_ge;

  assign pready = 1'b1;

  acrms_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .midpoint_level(midpoint_level),
    .window_length (window_length)
  );

  acrms_alu #(
    .WIDTH(UW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .diff(alu_diff),
    .ge  (alu_ge)
  );

  // Treat a zero window as one sample
  assign win = (window_length == '0) ? WINDOW_BITS'(1) : window_length;

  // Accumulate step values
  assign count_next  = armed ? count + COUNT_BITS'(1) : count;
  assign sum_next    = armed ? sum + SUM_BITS'(sq) : sum;
  assign window_done = (count_next != '0) && (COUNT_BITS'(count_next) >= COUNT_BITS'(win));

  // Feed the shared subtractor: divide shifts one bit in, root shifts two
  always_comb begin
    if (state == ST_SQRT) begin
      alu_a = {rem[UW-3:0], sum[MS_BITS-1 -: 2]};
      alu_b = UW'({root[SAMPLE_BITS-2:0], 2'b01});
    end else begin
      alu_a = {rem[UW-2:0], sum[SUM_BITS-1]};
      alu_b = UW'(count);
    end
  end

  assign sample_ready = (state == ST_IDLE);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prev         <= '0;
      armed        <= 1'b0;
      sum          <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            cur   <= sample;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sq <= MS_BITS'(cur) * MS_BITS'(cur);
          if (prev < midpoint_level && cur >= midpoint_level) begin
            armed <= 1'b1;
          end
          prev  <= cur;
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum   <= sum_next;
          count <= count_next;
          if (window_done) begin
            rem   <= '0;
            step  <= STEP_BITS'(SUM_BITS - 1);
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          sum <= {sum[SUM_BITS-2:0], alu_ge};
          if (step == '0) begin
            ms    <= {sum[MS_BITS-2:0], alu_ge};
            rem   <= '0;
            root  <= '0;
            step  <= STEP_BITS'(SAMPLE_BITS - 1);
            state <= ST_SQRT;
          end else begin
            rem  <= alu_ge ? alu_diff : alu_a;
            step <= step - STEP_BITS'(1);
          end
        end
        ST_SQRT: begin
          rem  <= alu_ge ? alu_diff : alu_a;
          root <= {root[SAMPLE_BITS-2:0], alu_ge};
          sum  <= {sum[SUM_BITS-3:0], 2'b00};
          if (step == '0) begin
            state <= ST_DONE;
          end else begin
            step <= step - STEP_BITS'(1);
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!result_valid || result_ready) begin
            rms_value    <= root;
            mean_square  <= ms;
            window_count <= count;
            result_valid <= 1'b1;
            sum          <= '0;
            count        <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/acrms_regs.sv
module acrms_regs
  import acrms_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic [SAMPLE_BITS-1:0] midpoint_level,
  output logic [WINDOW_BITS-1:0] window_length
);

  localparam logic [SAMPLE_BITS-1:0] MIDPOINT_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  reg_idx_t idx;

  assign idx = paddr[2];

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      midpoint_level <= MIDPOINT_RESET;
      window_length  <= WINDOW_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MIDPOINT: midpoint_level <= pwdata[SAMPLE_BITS-1:0];
        REG_WINDOW:   window_length  <= pwdata[WINDOW_BITS-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_MIDPOINT: prdata = DATA_BITS'(midpoint_level);
      REG_WINDOW:   prdata = DATA_BITS'(window_length);
    endcase
  end

endmodule

>>> src/acrms_alu.sv
module acrms_alu #(
  parameter int WIDTH = 12
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic borrow;

  // Trial subtract; no borrow means a >= b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

>>> src/acrms_checker.sv
`include "ac_rms_window_meter_unit_defines.svh"

module acrms_checker #(
  parameter int SAMPLE_BITS = 10
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     sample_valid,
  input logic                     sample_ready,
  input logic                     result_valid,
  input logic                     result_ready,
  input logic [SAMPLE_BITS-1:0]   rms_value,
  input logic [2*SAMPLE_BITS-1:0] mean_square,
  input logic [7:0]               window_count
);

  localparam int SQW = 2 * SAMPLE_BITS + 2;

  logic                     stalled;
  logic                     sample_accept;
  logic [3*SAMPLE_BITS+7:0] result_word;
  logic [SQW-1:0]           rms_wide;
  logic [SQW-1:0]           ms_wide;
  logic                     root_exact;

  assign stalled       = result_valid && !result_ready;
  assign sample_accept = sample_valid && sample_ready;
  assign result_word   = {rms_value, mean_square, window_count};
  assign rms_wide      = SQW'(rms_value);
  assign ms_wide       = SQW'(mean_square);
  assign root_exact    = (rms_wide * rms_wide <= ms_wide) &&
                         ((rms_wide + SQW'(1)) * (rms_wide + SQW'(1)) > ms_wide);

  // A waiting result holds its value
  `ACRMS_NEXT(a_result_hold, stalled, result_valid && $stable(result_word), "result changed")

  // An accepted item leaves the block busy in the following cycle
  `ACRMS_NEXT(a_busy_after_accept, sample_accept, !sample_ready, "ready after accept")

  // The root is the exact floor root of the mean square
  `ACRMS_IMPLY(a_root_exact, result_valid, root_exact, "root not exact")

  // A finished window holds at least one sample
  `ACRMS_IMPLY(a_count_nonzero, result_valid, window_count != 8'd0, "empty window reported")

endmodule

bind ac_rms_window_meter_unit acrms_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_acrms_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .rms_value   (rms_value),
  .mean_square (mean_square),
  .window_count(window_count)
);
